### rtl/core/bmpe_pkg.sv
// shared types, constants and spike step tables for the brush mask evaluator
`timescale 1ns / 1ps
package bmpe_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int OVERSAMPLE_DEF  = 4;
  localparam int COORD_BITS_DEF  = 12;

  localparam int QBITS      = 14;
  localparam int QHALF      = 8192;
  localparam int MAX_SPIKES = 20;
  localparam int MAX_FOLDS  = MAX_SPIKES / 2;
  localparam int FOLD_CNT_W = $clog2(MAX_FOLDS + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE  = 3'd0,
    REG_SPIKES = 3'd1,
    REG_COS    = 3'd2,
    REG_SIN    = 3'd3,
    REG_ASPECT = 3'd4,
    REG_RADIUS = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    SHAPE_CIRCLE  = 2'd0,
    SHAPE_SQUARE  = 2'd1,
    SHAPE_DIAMOND = 2'd2
  } shape_e;

  // per-word tag that rides along the pipeline
  typedef struct packed {
    logic        func;
    logic [11:0] tidx;
    logic [15:0] tword;
  } tag_t;

  // round(16384*cos(2*pi/n))
  function automatic logic signed [15:0] step_cos(input logic [4:0] n);
    logic signed [15:0] r;
    case (n)
      5'd3:    r = -16'sd8192;
      5'd4:    r = 16'sd0;
      5'd5:    r = 16'sd5063;
      5'd6:    r = 16'sd8192;
      5'd7:    r = 16'sd10215;
      5'd8:    r = 16'sd11585;
      5'd9:    r = 16'sd12551;
      5'd10:   r = 16'sd13255;
      5'd11:   r = 16'sd13783;
      5'd12:   r = 16'sd14189;
      5'd13:   r = 16'sd14507;
      5'd14:   r = 16'sd14761;
      5'd15:   r = 16'sd14968;
      5'd16:   r = 16'sd15137;
      5'd17:   r = 16'sd15278;
      5'd18:   r = 16'sd15396;
      5'd19:   r = 16'sd15496;
      5'd20:   r = 16'sd15582;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  // round(16384*sin(2*pi/n))
  function automatic logic signed [15:0] step_sin(input logic [4:0] n);
    logic signed [15:0] r;
    case (n)
      5'd3:    r = 16'sd14189;
      5'd4:    r = 16'sd16384;
      5'd5:    r = 16'sd15582;
      5'd6:    r = 16'sd14189;
      5'd7:    r = 16'sd12810;
      5'd8:    r = 16'sd11585;
      5'd9:    r = 16'sd10531;
      5'd10:   r = 16'sd9630;
      5'd11:   r = 16'sd8858;
      5'd12:   r = 16'sd8192;
      5'd13:   r = 16'sd7614;
      5'd14:   r = 16'sd7109;
      5'd15:   r = 16'sd6664;
      5'd16:   r = 16'sd6270;
      5'd17:   r = 16'sd5919;
      5'd18:   r = 16'sd5604;
      5'd19:   r = 16'sd5320;
      5'd20:   r = 16'sd5063;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/bmpe_fold.sv
// one sector fold step: product stage then compare and round stage
`timescale 1ns / 1ps
module bmpe_fold
  import bmpe_pkg::*;
#(
  parameter int PW   = 30,
  parameter int STEP = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  tag_t                   tag_i,
  input  logic signed [PW-1:0]   tx_i,
  input  logic signed [PW-1:0]   ty_i,
  input  logic                   stop_i,
  input  logic signed [15:0]     c_i,
  input  logic signed [15:0]     s_i,
  input  logic [FOLD_CNT_W-1:0]  nlim_i,
  output logic                   valid_o,
  output tag_t                   tag_o,
  output logic signed [PW-1:0]   tx_o,
  output logic signed [PW-1:0]   ty_o,
  output logic                   stop_o
);

  localparam int MW = PW + 16;
  localparam int SW = PW + 17;
  localparam logic [FOLD_CNT_W-1:0] STEP_L = FOLD_CNT_W'(STEP);

  logic                 valid_a_q;
  tag_t                 tag_a_q;
  logic signed [PW-1:0] tx_a_q, ty_a_q;
  logic                 stop_a_q;
  logic signed [MW-1:0] pct_q, pst_q, pcy_q, psx_q;

  logic                 valid_b_q;
  tag_t                 tag_b_q;
  logic signed [PW-1:0] tx_b_q, ty_b_q;
  logic                 stop_b_q;

  logic signed [SW-1:0] ntx, nty, txs, ntx_r, nty_r;
  logic                 take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_a_q  <= tag_i;
      tx_a_q   <= tx_i;
      ty_a_q   <= ty_i;
      stop_a_q <= stop_i || (nlim_i <= STEP_L);
      pct_q    <= MW'(c_i) * MW'(tx_i);
      pst_q    <= MW'(s_i) * MW'(ty_i);
      pcy_q    <= MW'(c_i) * MW'(ty_i);
      psx_q    <= MW'(s_i) * MW'(tx_i);
    end
  end

  always_comb begin
    ntx   = SW'(pct_q) + SW'(pst_q);
    nty   = SW'(pcy_q) - SW'(psx_q);
    txs   = SW'(tx_a_q) <<< QBITS;
    take  = !stop_a_q && (ntx > txs);
    ntx_r = (ntx + SW'(QHALF)) >>> QBITS;
    nty_r = (nty + SW'(QHALF)) >>> QBITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_b_q  <= tag_a_q;
      tx_b_q   <= take ? PW'(ntx_r) : tx_a_q;
      ty_b_q   <= take ? PW'(nty_r) : ty_a_q;
      stop_b_q <= !take;
    end
  end

  assign valid_o = valid_b_q;
  assign tag_o   = tag_b_q;
  assign tx_o    = tx_b_q;
  assign ty_o    = ty_b_q;
  assign stop_o  = stop_b_q;

endmodule

### rtl/core/bmpe_isqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module bmpe_isqrt
  import bmpe_pkg::*;
#(
  parameter int IN_W   = 52,
  parameter int SIDE_W = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [IN_W-1:0]       rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [IN_W/2-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int NS = IN_W / 2;
  localparam int RW = NS + 2;

  logic              valid_q [NS];
  logic [IN_W-1:0]   rad_q   [NS];
  logic [RW-1:0]     rem_q   [NS];
  logic [NS-1:0]     root_q  [NS];
  logic [SIDE_W-1:0] side_q  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic              v_in;
    logic [IN_W-1:0]   rad_in;
    logic [RW-1:0]     rem_in;
    logic [NS-1:0]     root_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW+1:0]     acc, trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign acc   = {rem_in, rad_in[IN_W-1 -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});
    assign ge    = acc >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]  <= rad_in << 2;
        rem_q[j]  <= ge ? RW'(acc - trial) : RW'(acc);
        root_q[j] <= {root_in[NS-2:0], ge};
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

### rtl/core/brush_mask_pixel_evaluator.sv
// brush mask pixel evaluator top level: rotation, sector fold, distance, falloff lookup
`timescale 1ns / 1ps
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   func, pixel_x, pixel_y, table_index, table_word
// out      output     out_valid_o / out_stall_i alpha (one word per pixel, none for table writes)
// cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// one word enters per cycle while in_stall_o is low; stages are 2 rotate, 2 per fold step times
// ten, 4 aspect and distance prep, 26 root stages and 2 table stages
// the whole pipeline advances together; it freezes only while a finished word is
// held at the output and out_stall_i is high, and then in_stall_o is high as well
// table writes go to memory at the lookup stage, in order with pixel reads
// reset clears the valid bits and loads register defaults; the table is not cleared
//
module brush_mask_pixel_evaluator
  import bmpe_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int OVERSAMPLE  = OVERSAMPLE_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] pixel_x_i,
  input  logic signed [COORD_BITS-1:0] pixel_y_i,
  input  logic [11:0]                  table_index_i,
  input  logic [15:0]                  table_word_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [15:0]                  alpha_o,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int PRW = COORD_BITS + 16;   // rotation products
  localparam int PW  = COORD_BITS + 18;   // rotated coordinates, with headroom
  localparam int APW = PW + 18;           // aspect product
  localparam int DW  = 25;                // coordinates below rlim
  localparam int SQW = 2 * DW + 2;        // root input, even width
  localparam int RTW = SQW / 2;           // root and distance width

  typedef struct packed {
    tag_t           tag;
    logic           kill;
    logic           use_root;
    logic [RTW-1:0] dalt;
  } side_t;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [1:0]         shape_q;
  logic [4:0]         spike_q;
  logic signed [15:0] cos_q, sin_q;
  logic [17:0]        aspect_q;
  logic [13:0]        radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= SHAPE_CIRCLE;
      spike_q  <= 5'd2;
      cos_q    <= 16'sd16384;
      sin_q    <= 16'sd0;
      aspect_q <= 18'd256;
      radius_q <= 14'd80;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SHAPE:  shape_q  <= cfg_data_i[1:0];
        REG_SPIKES: spike_q  <= cfg_data_i[4:0];
        REG_COS:    cos_q    <= cfg_data_i[15:0];
        REG_SIN:    sin_q    <= cfg_data_i[15:0];
        REG_ASPECT: aspect_q <= cfg_data_i;
        REG_RADIUS: radius_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // derived settings; the user must keep them stable while any word is in flight, the block does not enforce it
  logic [4:0]            n_eff;
  logic [FOLD_CNT_W-1:0] nlim;
  logic signed [15:0]    step_c, step_s;
  logic [DW-1:0]         rlim;

  always_comb begin
    n_eff  = (spike_q > 5'(MAX_SPIKES)) ? 5'(MAX_SPIKES) : spike_q;
    nlim   = (n_eff > 5'd2) ? FOLD_CNT_W'(n_eff >> 1) : '0;
    step_c = step_cos(n_eff);
    step_s = step_sin(n_eff);
    rlim   = {DW'(radius_q) + DW'(16)} << 10;   // radius_q/16 + 1 in Q.14
  end

  // ------------------------------------------------------------------
  // global advance: hold everything while the output word is stalled
  // ------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  tag_t in_tag;
  assign in_tag = '{func: func_i, tidx: table_index_i, tword: table_word_i};

  // ------------------------------------------------------------------
  // rotation: products, then sums and vertical fold
  // ------------------------------------------------------------------
  logic                  s1_valid_q;
  tag_t                  s1_tag_q;
  logic signed [PRW-1:0] pcx_q, psy_q, psx_q, pcy_q;

  logic                  s2_valid_q;
  tag_t                  s2_tag_q;
  logic signed [PW-1:0]  s2_tx_q, s2_ty_q;
  logic signed [PW-1:0]  ty_sum;

  assign ty_sum = PW'(psx_q) + PW'(pcy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_tag_q <= in_tag;
      pcx_q    <= PRW'(cos_q) * PRW'(pixel_x_i);
      psy_q    <= PRW'(sin_q) * PRW'(pixel_y_i);
      psx_q    <= PRW'(sin_q) * PRW'(pixel_x_i);
      pcy_q    <= PRW'(cos_q) * PRW'(pixel_y_i);
      s2_tag_q <= s1_tag_q;
      s2_tx_q  <= PW'(pcx_q) - PW'(psy_q);
      s2_ty_q  <= (ty_sum < 0) ? -ty_sum : ty_sum;
    end
  end

  // ------------------------------------------------------------------
  // sector folding: one step per two stages, each step may rotate back
  // by 2*pi/n while the angle is still beyond pi/n
  // ------------------------------------------------------------------
  logic                 f_valid [MAX_FOLDS+1];
  tag_t                 f_tag   [MAX_FOLDS+1];
  logic signed [PW-1:0] f_tx    [MAX_FOLDS+1];
  logic signed [PW-1:0] f_ty    [MAX_FOLDS+1];
  logic                 f_stop  [MAX_FOLDS+1];

  assign f_valid[0] = s2_valid_q;
  assign f_tag[0]   = s2_tag_q;
  assign f_tx[0]    = s2_tx_q;
  assign f_ty[0]    = s2_ty_q;
  assign f_stop[0]  = 1'b0;

  for (genvar k = 0; k < MAX_FOLDS; k++) begin : g_fold
    bmpe_fold #(
      .PW   (PW),
      .STEP (k)
    ) u_fold (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (f_valid[k]),
      .tag_i   (f_tag[k]),
      .tx_i    (f_tx[k]),
      .ty_i    (f_ty[k]),
      .stop_i  (f_stop[k]),
      .c_i     (step_c),
      .s_i     (step_s),
      .nlim_i  (nlim),
      .valid_o (f_valid[k+1]),
      .tag_o   (f_tag[k+1]),
      .tx_o    (f_tx[k+1]),
      .ty_o    (f_ty[k+1]),
      .stop_o  (f_stop[k+1])
    );
  end

  // ------------------------------------------------------------------
  // aspect scaling and radius check
  // ------------------------------------------------------------------
  logic                 a1_valid_q;
  tag_t                 a1_tag_q;
  logic [PW-1:0]        a1_ax_q;
  logic [APW-1:0]       a1_ayp_q;
  logic signed [PW-1:0] fx, fy;
  logic [PW-1:0]        fx_abs, fy_abs;

  assign fx     = f_tx[MAX_FOLDS];
  assign fy     = f_ty[MAX_FOLDS];
  assign fx_abs = (fx < 0) ? PW'(-fx) : PW'(fx);
  assign fy_abs = (fy < 0) ? PW'(-fy) : PW'(fy);

  logic          a2_valid_q;
  tag_t          a2_tag_q;
  logic          a2_kill_q;
  logic [DW-1:0] a2_ax_q, a2_ay_q;
  logic [APW-1:0] ay_full;
  logic           over;

  always_comb begin
    ay_full = (a1_ayp_q + APW'(128)) >> 8;
    over    = (APW'(a1_ax_q) >= APW'(rlim)) || (ay_full >= APW'(rlim));
  end

  // distance prep: squares for circle, max or sum for the others
  logic              a3_valid_q;
  logic [2*DW-1:0]   a3_axx_q, a3_ayy_q;
  side_t             a3_side_q;
  logic [RTW-1:0]    dalt;
  logic              shape_sq, shape_dm;

  always_comb begin
    shape_sq = (shape_q == SHAPE_SQUARE);
    shape_dm = (shape_q == SHAPE_DIAMOND);
    if (shape_sq) begin
      dalt = (a2_ax_q > a2_ay_q) ? RTW'(a2_ax_q) : RTW'(a2_ay_q);
    end else begin
      dalt = RTW'(a2_ax_q) + RTW'(a2_ay_q);
    end
  end

  logic           a4_valid_q;
  logic [SQW-1:0] a4_rad_q;
  side_t          a4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_valid_q <= 1'b0;
      a2_valid_q <= 1'b0;
      a3_valid_q <= 1'b0;
      a4_valid_q <= 1'b0;
    end else if (en) begin
      a1_valid_q <= f_valid[MAX_FOLDS];
      a2_valid_q <= a1_valid_q;
      a3_valid_q <= a2_valid_q;
      a4_valid_q <= a3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_tag_q  <= f_tag[MAX_FOLDS];
      a1_ax_q   <= fx_abs;
      a1_ayp_q  <= APW'(fy_abs) * APW'(aspect_q);
      a2_tag_q  <= a1_tag_q;
      a2_kill_q <= over;
      a2_ax_q   <= DW'(a1_ax_q);
      a2_ay_q   <= DW'(ay_full);
      a3_axx_q  <= (2*DW)'(a2_ax_q) * (2*DW)'(a2_ax_q);
      a3_ayy_q  <= (2*DW)'(a2_ay_q) * (2*DW)'(a2_ay_q);
      a3_side_q <= '{tag: a2_tag_q, kill: a2_kill_q,
                     use_root: !(shape_sq || shape_dm), dalt: dalt};
      a4_rad_q  <= SQW'(a3_axx_q) + SQW'(a3_ayy_q);
      a4_side_q <= a3_side_q;
    end
  end

  // ------------------------------------------------------------------
  // euclidean distance
  // ------------------------------------------------------------------
  logic           r_valid;
  logic [RTW-1:0] r_root;
  side_t          r_side;
  logic [$bits(side_t)-1:0] r_side_bits;

  bmpe_isqrt #(
    .IN_W   (SQW),
    .SIDE_W ($bits(side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a4_valid_q),
    .rad_i   (a4_rad_q),
    .side_i  (a4_side_q),
    .valid_o (r_valid),
    .root_o  (r_root),
    .side_o  (r_side_bits)
  );

  assign r_side = r_side_bits;

  // ------------------------------------------------------------------
  // table index and lookup
  // ------------------------------------------------------------------
  logic [RTW-1:0] dist_sel;
  logic [31:0]    idx_full;
  logic           t_kill;
  logic           t_we;

  always_comb begin
    dist_sel = r_side.use_root ? r_root : r_side.dalt;
    idx_full = (32'(dist_sel) * 32'(OVERSAMPLE) + 32'(QHALF)) >> QBITS;
    t_kill   = r_side.kill || (32'(dist_sel) >= 32'(rlim)) ||
               (idx_full >= 32'(TABLE_DEPTH));
    t_we     = !r_side.tag.func && (32'(r_side.tag.tidx) < 32'(TABLE_DEPTH));
  end

  logic          t1_valid_q;
  logic          t1_func_q;
  logic          t1_we_q;
  logic          t1_kill_q;
  logic [AW-1:0] t1_addr_q;
  logic [15:0]   t1_wdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      t1_valid_q  <= r_valid;
      out_valid_q <= t1_valid_q && t1_func_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_func_q  <= r_side.tag.func;
      t1_we_q    <= t_we;
      t1_kill_q  <= t_kill;
      t1_addr_q  <= r_side.tag.func ? AW'(idx_full) : AW'(r_side.tag.tidx);
      t1_wdata_q <= r_side.tag.tword;
    end
  end

  // falloff table: writes and reads meet here in stream order
  logic [15:0] table_mem [TABLE_DEPTH];
  logic [15:0] rdata_q;
  logic        out_kill_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (t1_valid_q && t1_we_q) begin
        table_mem[t1_addr_q] <= t1_wdata_q;
      end
      rdata_q    <= table_mem[t1_addr_q];
      out_kill_q <= t1_kill_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign alpha_o     = out_kill_q ? 16'd0 : rdata_q;

endmodule
